[src/kcbt_pkg.sv]
// -----------------------------------------------------------------------------
// Box tracker package
// Shared types, microprogram and fixed-point helpers for the Kalman box tracker.
// -----------------------------------------------------------------------------
`default_nettype none

package kcbt_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int PROG_AW = 4;

	localparam logic [1:0] CFG_NOISE_POS  = 2'd0;
	localparam logic [1:0] CFG_NOISE_VEL  = 2'd1;
	localparam logic [1:0] CFG_NOISE_MEAS = 2'd2;

	localparam logic [PROG_AW-1:0] PC_PRED = 4'd0;
	localparam logic [PROG_AW-1:0] PC_UPD  = 4'd4;
	localparam logic [PROG_AW-1:0] PC_INIT = 4'd12;

	typedef enum logic [3:0] {
		K_XPRED, K_PROW, K_PCOL, K_PNOISE, K_INNOV, K_ACOPY, K_DIV, K_ELIM,
		K_GAIN, K_XUPD, K_SAVE, K_PUPD, K_XLOAD, K_PLOAD
	} kind_t;

	typedef enum logic [3:0] {
		S_MEM, S_X, S_Y, S_Z, S_DT, S_NP, S_NV, S_NM, S_ONE, S_TEN, S_ZERO, S_F
	} src_t;

	typedef enum logic [1:0] {D_NONE, D_MEM, D_X, D_Y} dst_t;

	typedef enum logic [1:0] {J_NEXT, J_LOOPI, J_DONE} jmp_t;

	typedef enum logic [1:0] {RES_ZERO, RES_ECHO, RES_STATE} res_t;

	typedef struct packed {
		kind_t              kind;
		logic [2:0]         rmax;
		logic [2:0]         cmax;
		logic [1:0]         jmax;
		logic               mul_en;
		jmp_t               jmp;
		logic [PROG_AW-1:0] target;
	} ctrl_t;

	typedef struct packed {
		src_t       src;
		logic [6:0] addr;
		logic [2:0] idx;
	} opnd_t;

	// Covariance at 0..63, work matrix at 64..95, gain at 96..127.
	function automatic logic [6:0] p_addr(input logic [2:0] r, input logic [2:0] c);
		return {1'b0, r, c};
	endfunction

	function automatic logic [6:0] a_addr(input logic [1:0] r, input logic [2:0] c);
		return {2'b10, r, c};
	endfunction

	function automatic logic [6:0] k_addr(input logic [2:0] r, input logic [1:0] c);
		return {2'b11, r, c};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] s;
		if (v > 64'sd2147483647) begin
			s = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			s = 32'sh80000000;
		end else begin
			s = v[31:0];
		end
		return s;
	endfunction

	function automatic ctrl_t prog_word(input logic [PROG_AW-1:0] pc);
		ctrl_t w;
		unique case (pc)
			4'd0: w = '{K_XPRED, 3'd3, 3'd0, 2'd0, 1'b1, J_NEXT, 4'd0};
			4'd1: w = '{K_PROW, 3'd3, 3'd7, 2'd0, 1'b1, J_NEXT, 4'd0};
			4'd2: w = '{K_PCOL, 3'd7, 3'd3, 2'd0, 1'b1, J_NEXT, 4'd0};
			4'd3: w = '{K_PNOISE, 3'd7, 3'd0, 2'd0, 1'b1, J_DONE, 4'd0};
			4'd4: w = '{K_INNOV, 3'd3, 3'd0, 2'd0, 1'b1, J_NEXT, 4'd0};
			4'd5: w = '{K_ACOPY, 3'd3, 3'd7, 2'd0, 1'b1, J_NEXT, 4'd0};
			4'd6: w = '{K_DIV, 3'd0, 3'd7, 2'd0, 1'b0, J_NEXT, 4'd0};
			4'd7: w = '{K_ELIM, 3'd3, 3'd7, 2'd0, 1'b1, J_LOOPI, 4'd6};
			4'd8: w = '{K_GAIN, 3'd7, 3'd3, 2'd3, 1'b1, J_NEXT, 4'd0};
			4'd9: w = '{K_XUPD, 3'd7, 3'd0, 2'd3, 1'b1, J_NEXT, 4'd0};
			4'd10: w = '{K_SAVE, 3'd3, 3'd7, 2'd0, 1'b0, J_NEXT, 4'd0};
			4'd11: w = '{K_PUPD, 3'd7, 3'd7, 2'd3, 1'b1, J_DONE, 4'd0};
			4'd12: w = '{K_XLOAD, 3'd7, 3'd0, 2'd0, 1'b0, J_NEXT, 4'd0};
			4'd13: w = '{K_PLOAD, 3'd7, 3'd7, 2'd0, 1'b0, J_DONE, 4'd0};
			default: w = '{K_XLOAD, 3'd7, 3'd0, 2'd0, 1'b0, J_DONE, 4'd0};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[src/kcbt_if.sv]
// -----------------------------------------------------------------------------
// Box tracker channels
// Valid/ready channels for requests, results and register writes.
// -----------------------------------------------------------------------------
`default_nettype none

interface kcbt_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [30:0]        time_step;
	logic signed [31:0] meas_x;
	logic signed [31:0] meas_y;
	logic signed [31:0] meas_w;
	logic signed [31:0] meas_h;
	modport source (output valid, req_type, time_step, meas_x, meas_y, meas_w, meas_h,
		input ready);
	modport sink (input valid, req_type, time_step, meas_x, meas_y, meas_w, meas_h,
		output ready);
endinterface

interface kcbt_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] box_x;
	logic signed [31:0] box_y;
	logic signed [31:0] box_w;
	logic signed [31:0] box_h;
	modport source (output valid, box_x, box_y, box_w, box_h, input ready);
	modport sink (input valid, box_x, box_y, box_w, box_h, output ready);
endinterface

interface kcbt_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [30:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/kalman_cv_box_tracker.sv]
// -----------------------------------------------------------------------------
// Kalman box tracker
// Eight-state constant-velocity Kalman filter on one bounding box, run by a
// microprogram over one shared multiply-accumulate path and a serial divider.
// -----------------------------------------------------------------------------
//
//   channel  dir  payload                                   transfer when
//   req      in   req_type, time_step, meas_x/y/w/h          valid & ready
//   res      out  box_x, box_y, box_w, box_h                 valid & ready
//   cfg      in   index, data (noise registers 0..2)         valid & ready
//
// A predict and an update each run their part of the microprogram; each element of
// the multiply-accumulate path is built from its products in turn, and
// the one bit per cycle divider of the Gauss-Jordan pass forms each pivot row element.
// A predict before tracking starts returns a zero box without running the microprogram.
// After reset the block is ready at once; no memory clearing is needed.
// A result waits in the output register while the next request is taken.
`default_nettype none

module kalman_cv_box_tracker
	import kcbt_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	kcbt_req_if.sink   req,
	kcbt_res_if.source res,
	kcbt_cfg_if.sink   cfg
);

	localparam logic signed [31:0] ONE_FX   = 32'(1 << FRAC_BITS);
	localparam logic signed [31:0] TEN_FX   = 32'(10 << FRAC_BITS);
	localparam logic signed [31:0] EPS_FX   = 32'sd1;
	localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);

	typedef enum logic [15:0] {
		ST_IDLE  = 16'b0000_0000_0000_0001,
		ST_START = 16'b0000_0000_0000_0010,
		ST_LOAD  = 16'b0000_0000_0000_0100,
		ST_PRE   = 16'b0000_0000_0000_1000,
		ST_PRE_W = 16'b0000_0000_0001_0000,
		ST_INIT  = 16'b0000_0000_0010_0000,
		ST_INIT_W = 16'b0000_0000_0100_0000,
		ST_OPRD  = 16'b0000_0000_1000_0000,
		ST_MUL   = 16'b0000_0001_0000_0000,
		ST_RND   = 16'b0000_0010_0000_0000,
		ST_ACC   = 16'b0000_0100_0000_0000,
		ST_DIVS  = 16'b0000_1000_0000_0000,
		ST_DIV   = 16'b0001_0000_0000_0000,
		ST_DIVF  = 16'b0010_0000_0000_0000,
		ST_WR    = 16'b0100_0000_0000_0000,
		ST_OUT   = 16'b1000_0000_0000_0000
	} state_t;

	state_t             st_q;
	logic [PROG_AW-1:0] pc_q;
	logic [2:0]         r_q;
	logic [2:0]         c_q;
	logic [1:0]         j_q;
	logic [1:0]         i_q;
	logic [4:0]         dcnt_q;
	logic               started_q;
	res_t               res_sel_q;
	logic               ovalid_q;
	logic [30:0]        np_q;
	logic [30:0]        nv_q;
	logic [30:0]        nm_q;

	logic signed [31:0] mem_q [128];
	logic signed [31:0] x_q [8];
	logic signed [31:0] y_q [4];
	logic signed [31:0] z_q [4];
	logic [30:0]        dt_q;
	logic               type_q;
	logic signed [31:0] rd0_q;
	logic signed [31:0] rd1_q;
	logic signed [31:0] acc_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] rnd_q;
	logic signed [31:0] piv_q;
	logic signed [31:0] f_q;
	logic [63:0]        rem_q;
	logic [63:0]        dsh_q;
	logic [31:0]        quo_q;
	logic               ovf_q;
	logic               neg_q;
	logic signed [31:0] box_x_q;
	logic signed [31:0] box_y_q;
	logic signed [31:0] box_w_q;
	logic signed [31:0] box_h_q;

	ctrl_t              cw;
	opnd_t              op_pre;
	opnd_t              op_init;
	opnd_t              op_a;
	opnd_t              op_b;
	dst_t               dsel;
	logic [6:0]         daddr;
	logic [2:0]         didx;
	logic               sub_c;
	logic [6:0]         addr0;
	logic signed [31:0] init_val;
	logic signed [31:0] a_val;
	logic signed [31:0] b_val;
	logic signed [63:0] mul_c;
	logic signed [63:0] acc_sum;
	logic signed [63:0] num_c;
	logic [63:0]        magn_c;
	logic [63:0]        magd_c;
	logic [63:0]        dtop_c;
	logic               ge_c;
	logic signed [31:0] div_res;
	logic [3:0]         nr_c;
	logic               last_c;
	logic               last_r;
	logic               pre_kind;
	logic               req_fire;
	logic               out_load;

	function automatic logic signed [31:0] pick(input opnd_t o, input logic signed [31:0] md);
		logic signed [31:0] v;
		unique case (o.src)
			S_MEM:  v = md;
			S_X:    v = x_q[o.idx];
			S_Y:    v = y_q[o.idx[1:0]];
			S_Z:    v = z_q[o.idx[1:0]];
			S_DT:   v = {1'b0, dt_q};
			S_NP:   v = {1'b0, np_q};
			S_NV:   v = {1'b0, nv_q};
			S_NM:   v = {1'b0, nm_q};
			S_ONE:  v = ONE_FX;
			S_TEN:  v = TEN_FX;
			S_F:    v = f_q;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign cw = prog_word(pc_q);

	always_comb begin
		op_pre  = '{S_MEM, 7'd0, 3'd0};
		op_init = '{S_ZERO, 7'd0, 3'd0};
		op_a    = '{S_ZERO, 7'd0, 3'd0};
		op_b    = '{S_ONE, 7'd0, 3'd0};
		dsel    = D_NONE;
		daddr   = p_addr(r_q, c_q);
		didx    = r_q;
		sub_c   = 1'b0;
		unique case (cw.kind)
			K_XPRED: begin
				op_init = '{S_X, 7'd0, r_q};
				op_a    = '{S_DT, 7'd0, 3'd0};
				op_b    = '{S_X, 7'd0, {1'b1, r_q[1:0]}};
				dsel    = D_X;
			end
			K_PROW: begin
				op_init = '{S_MEM, p_addr(r_q, c_q), 3'd0};
				op_a    = '{S_DT, 7'd0, 3'd0};
				op_b    = '{S_MEM, p_addr({1'b1, r_q[1:0]}, c_q), 3'd0};
				dsel    = D_MEM;
			end
			K_PCOL: begin
				op_init = '{S_MEM, p_addr(r_q, c_q), 3'd0};
				op_a    = '{S_DT, 7'd0, 3'd0};
				op_b    = '{S_MEM, p_addr(r_q, {1'b1, c_q[1:0]}), 3'd0};
				dsel    = D_MEM;
			end
			K_PNOISE: begin
				op_init = '{S_MEM, p_addr(r_q, r_q), 3'd0};
				op_a    = '{(r_q[2] ? S_NV : S_NP), 7'd0, 3'd0};
				dsel    = D_MEM;
				daddr   = p_addr(r_q, r_q);
			end
			K_INNOV: begin
				op_init = '{S_Z, 7'd0, r_q};
				op_a    = '{S_X, 7'd0, r_q};
				sub_c   = 1'b1;
				dsel    = D_Y;
			end
			K_ACOPY: begin
				if (c_q[2]) begin
					op_init = '{((c_q[1:0] == r_q[1:0]) ? S_ONE : S_ZERO), 7'd0, 3'd0};
				end else begin
					op_init = '{S_MEM, p_addr(r_q, c_q), 3'd0};
				end
				op_a  = '{((c_q == r_q) ? S_NM : S_ZERO), 7'd0, 3'd0};
				dsel  = D_MEM;
				daddr = a_addr(r_q[1:0], c_q);
			end
			K_DIV: begin
				op_pre  = '{S_MEM, a_addr(i_q, {1'b0, i_q}), 3'd0};
				op_init = '{S_MEM, a_addr(i_q, c_q), 3'd0};
				dsel    = D_MEM;
				daddr   = a_addr(i_q, c_q);
			end
			K_ELIM: begin
				op_pre  = '{S_MEM, a_addr(r_q[1:0], {1'b0, i_q}), 3'd0};
				op_init = '{S_MEM, a_addr(r_q[1:0], c_q), 3'd0};
				op_a    = '{S_F, 7'd0, 3'd0};
				op_b    = '{S_MEM, a_addr(i_q, c_q), 3'd0};
				sub_c   = 1'b1;
				dsel    = D_MEM;
				daddr   = a_addr(r_q[1:0], c_q);
			end
			K_GAIN: begin
				op_a  = '{S_MEM, p_addr(r_q, {1'b0, j_q}), 3'd0};
				op_b  = '{S_MEM, a_addr(j_q, {1'b1, c_q[1:0]}), 3'd0};
				dsel  = D_MEM;
				daddr = k_addr(r_q, c_q[1:0]);
			end
			K_XUPD: begin
				op_init = '{S_X, 7'd0, r_q};
				op_a    = '{S_MEM, k_addr(r_q, j_q), 3'd0};
				op_b    = '{S_Y, 7'd0, {1'b0, j_q}};
				dsel    = D_X;
			end
			K_SAVE: begin
				op_init = '{S_MEM, p_addr(r_q, c_q), 3'd0};
				dsel    = D_MEM;
				daddr   = a_addr(r_q[1:0], c_q);
			end
			K_PUPD: begin
				op_init = '{S_MEM, p_addr(r_q, c_q), 3'd0};
				op_a    = '{S_MEM, k_addr(r_q, j_q), 3'd0};
				op_b    = '{S_MEM, a_addr(j_q, c_q), 3'd0};
				sub_c   = 1'b1;
				dsel    = D_MEM;
			end
			K_XLOAD: begin
				op_init = '{(r_q[2] ? S_ZERO : S_Z), 7'd0, r_q};
				dsel    = D_X;
			end
			K_PLOAD: begin
				op_init = '{((r_q == c_q) ? S_TEN : S_ZERO), 7'd0, 3'd0};
				dsel    = D_MEM;
			end
			default: begin
				dsel = D_NONE;
			end
		endcase
	end

	always_comb begin
		if (st_q == ST_PRE) begin
			addr0 = op_pre.addr;
		end else if (st_q == ST_INIT) begin
			addr0 = op_init.addr;
		end else begin
			addr0 = op_a.addr;
		end
	end

	always_comb begin
		init_val = pick(op_init, rd0_q);
		a_val    = pick(op_a, rd0_q);
		b_val    = pick(op_b, rd1_q);
	end

	assign mul_c    = a_val * b_val;
	assign acc_sum  = sub_c ? (64'(acc_q) - rnd_q) : (64'(acc_q) + rnd_q);

	assign num_c   = 64'(acc_q) <<< FRAC_BITS;
	assign magn_c  = num_c[63] ? $unsigned(-num_c) : $unsigned(num_c);
	assign magd_c  = piv_q[31] ? $unsigned(-64'(piv_q)) : $unsigned(64'(piv_q));
	assign dtop_c  = magd_c << 31;
	assign ge_c    = rem_q >= dsh_q;
	assign div_res = ovf_q ? (neg_q ? 32'sh80000000 : 32'sh7fffffff)
		: $signed(neg_q ? (32'd0 - quo_q) : quo_q);

	assign pre_kind = (cw.kind == K_DIV) || (cw.kind == K_ELIM);
	assign last_c   = (c_q == cw.cmax);

	always_comb begin
		nr_c = {1'b0, r_q} + 4'd1;
		if (cw.kind == K_ELIM && nr_c == {2'b00, i_q}) begin
			nr_c = nr_c + 4'd1;
		end
		last_r = nr_c > {1'b0, cw.rmax};
	end

	assign req_fire  = req.valid && req.ready;
	assign out_load  = (st_q == ST_OUT) && (!ovalid_q || res.ready);
	assign req.ready = (st_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign res.valid = ovalid_q;
	assign res.box_x = box_x_q;
	assign res.box_y = box_y_q;
	assign res.box_w = box_w_q;
	assign res.box_h = box_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			pc_q      <= '0;
			r_q       <= '0;
			c_q       <= '0;
			j_q       <= '0;
			i_q       <= '0;
			dcnt_q    <= '0;
			started_q <= 1'b0;
			res_sel_q <= RES_ZERO;
			ovalid_q  <= 1'b0;
			np_q      <= 31'd65536;
			nv_q      <= 31'd655;
			nm_q      <= 31'd65536;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					CFG_NOISE_POS:  np_q <= cfg.data;
					CFG_NOISE_VEL:  nv_q <= cfg.data;
					CFG_NOISE_MEAS: nm_q <= cfg.data;
					default: ;
				endcase
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (res.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (req_fire) begin
						st_q <= ST_START;
					end
				end
				ST_START: begin
					i_q <= '0;
					if (!type_q) begin
						if (!started_q) begin
							res_sel_q <= RES_ZERO;
							st_q      <= ST_OUT;
						end else begin
							res_sel_q <= RES_STATE;
							pc_q      <= PC_PRED;
							st_q      <= ST_LOAD;
						end
					end else if (!started_q) begin
						res_sel_q <= RES_ECHO;
						started_q <= 1'b1;
						pc_q      <= PC_INIT;
						st_q      <= ST_LOAD;
					end else begin
						res_sel_q <= RES_STATE;
						pc_q      <= PC_UPD;
						st_q      <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					r_q  <= (cw.kind == K_ELIM && i_q == 2'd0) ? 3'd1 : 3'd0;
					c_q  <= '0;
					j_q  <= '0;
					st_q <= pre_kind ? ST_PRE : ST_INIT;
				end
				ST_PRE: st_q <= ST_PRE_W;
				ST_PRE_W: st_q <= ST_INIT;
				ST_INIT: st_q <= ST_INIT_W;
				ST_INIT_W: begin
					j_q <= '0;
					if (cw.kind == K_DIV) begin
						st_q <= ST_DIVS;
					end else if (cw.mul_en) begin
						st_q <= ST_OPRD;
					end else begin
						st_q <= ST_WR;
					end
				end
				ST_OPRD: st_q <= ST_MUL;
				ST_MUL: st_q <= ST_RND;
				ST_RND: st_q <= ST_ACC;
				ST_ACC: begin
					if (j_q == cw.jmax) begin
						st_q <= ST_WR;
					end else begin
						j_q  <= j_q + 2'd1;
						st_q <= ST_OPRD;
					end
				end
				ST_DIVS: begin
					dcnt_q <= 5'd31;
					st_q   <= ST_DIV;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q - 5'd1;
					if (dcnt_q == 5'd0) begin
						st_q <= ST_DIVF;
					end
				end
				ST_DIVF: st_q <= ST_WR;
				ST_WR: begin
					if (!last_c) begin
						c_q  <= c_q + 3'd1;
						st_q <= ST_INIT;
					end else if (!last_r) begin
						c_q  <= '0;
						r_q  <= nr_c[2:0];
						st_q <= pre_kind ? ST_PRE : ST_INIT;
					end else begin
						unique case (cw.jmp)
							J_NEXT: begin
								pc_q <= pc_q + 4'd1;
								st_q <= ST_LOAD;
							end
							J_LOOPI: begin
								if (i_q != 2'd3) begin
									i_q  <= i_q + 2'd1;
									pc_q <= cw.target;
								end else begin
									pc_q <= pc_q + 4'd1;
								end
								st_q <= ST_LOAD;
							end
							default: st_q <= ST_OUT;
						endcase
					end
				end
				ST_OUT: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd0_q <= mem_q[addr0];
		rd1_q <= mem_q[op_b.addr];
		if (req_fire) begin
			type_q <= req.req_type;
			dt_q   <= req.time_step;
			z_q[0] <= req.meas_x;
			z_q[1] <= req.meas_y;
			z_q[2] <= req.meas_w;
			z_q[3] <= req.meas_h;
		end
		if (st_q == ST_PRE_W) begin
			if (cw.kind == K_DIV) begin
				piv_q <= (rd0_q == 32'sd0) ? EPS_FX : rd0_q;
			end else begin
				f_q <= rd0_q;
			end
		end
		if (st_q == ST_INIT_W) begin
			acc_q <= init_val;
		end
		if (st_q == ST_MUL) begin
			prod_q <= mul_c;
		end
		if (st_q == ST_RND) begin
			rnd_q <= 64'(sat32((prod_q + HALF_LSB) >>> FRAC_BITS));
		end
		if (st_q == ST_ACC) begin
			acc_q <= sat32(acc_sum);
		end
		if (st_q == ST_DIVS) begin
			rem_q <= magn_c;
			dsh_q <= dtop_c;
			quo_q <= '0;
			ovf_q <= magn_c >= dtop_c;
			neg_q <= acc_q[31] ^ piv_q[31];
		end
		if (st_q == ST_DIV) begin
			if (ge_c) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[30:0], ge_c};
			dsh_q <= dsh_q >> 1;
		end
		if (st_q == ST_DIVF) begin
			acc_q <= div_res;
		end
		if (st_q == ST_WR) begin
			unique case (dsel)
				D_MEM: mem_q[daddr] <= acc_q;
				D_X:   x_q[didx] <= acc_q;
				D_Y:   y_q[didx[1:0]] <= acc_q;
				default: ;
			endcase
		end
		if (out_load) begin
			unique case (res_sel_q)
				RES_ECHO: begin
					box_x_q <= z_q[0];
					box_y_q <= z_q[1];
					box_w_q <= z_q[2];
					box_h_q <= z_q[3];
				end
				RES_STATE: begin
					box_x_q <= x_q[0];
					box_y_q <= x_q[1];
					box_w_q <= (x_q[2] > ONE_FX) ? x_q[2] : ONE_FX;
					box_h_q <= (x_q[3] > ONE_FX) ? x_q[3] : ONE_FX;
				end
				default: begin
					box_x_q <= '0;
					box_y_q <= '0;
					box_w_q <= '0;
					box_h_q <= '0;
				end
			endcase
		end
	end

	// A request is held off until its result has been handed to the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while another is in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> (piv_q != 32'sd0))
		else $error("divider running on a zero pivot");

	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ACC) |-> (j_q <= cw.jmax))
		else $error("product index beyond the microcode bound");

	assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(started_q))
		else $error("tracking flag cleared outside reset");

endmodule

`default_nettype wire
